@@ rtl/core/dbt_pkg.sv @@
// Shared constants, types and codes for the depth buffer test unit.
package dbt_pkg;

  // Depth store geometry.
  localparam int unsigned STORE_ENTRIES = 32768;
  localparam int unsigned STORE_AW = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;

  // Field and register widths.
  localparam int unsigned DEPTH_W   = 24;
  localparam int unsigned MAXD_W    = 23;
  localparam int unsigned WIDTH_W   = 9;
  localparam int unsigned HEIGHT_W  = 8;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned IDX_SUM_W = HEIGHT_W + WIDTH_W + 1;

  // Configuration register reset values.
  localparam logic              TEST_ENABLE_RST   = 1'b1;
  localparam logic [MAXD_W-1:0] MAX_DEPTH_RST     = MAXD_W'(7680);
  localparam logic [WIDTH_W-1:0]  SCREEN_WIDTH_RST  = WIDTH_W'(120);
  localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST = HEIGHT_W'(40);

  // Configuration port.
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  // Queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = QPTR_W + 1;

  typedef enum logic [1:0] {
    REG_TEST_ENABLE,
    REG_MAX_DEPTH,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT
  } reg_index_t;

  typedef struct packed {
    logic                test_enable;
    logic [MAXD_W-1:0]   max_depth;
    logic [WIDTH_W-1:0]  screen_width;
    logic [HEIGHT_W-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic signed [DEPTH_W-1:0] depth;
  } in_req_t;

  typedef struct packed {
    logic passed;
    logic cleared;
  } out_rsp_t;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_FAIL,
    KIND_TEST,
    KIND_CLEAR
  } item_kind_t;

  typedef struct packed {
    item_kind_t                kind;
    logic [STORE_AW-1:0]       idx;
    logic signed [DEPTH_W-1:0] depth;
  } queue_entry_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_SWEEP
  } back_state_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

@@ rtl/core/dbt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dbt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/dbt_queue.sv @@
// Short request queue between the classifying front part and the back part.
module dbt_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dbt_pkg::queue_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output dbt_pkg::queue_entry_t pop_entry,
  output logic                  empty
);
  import dbt_pkg::*;

  queue_entry_t      entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    full  = (count_r == QCNT_W'(QUEUE_DEPTH));
    empty = (count_r == '0);
    pop_entry = entries_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/core/dbt_front.sv @@
// Front part: accepts requests, checks bounds and depth, and forms the store index.
module dbt_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  dbt_pkg::in_req_t      in_req,
  input  dbt_pkg::cfg_t         cfg,
  input  dbt_pkg::back_status_t bk_status,
  output logic                  q_push,
  output dbt_pkg::queue_entry_t q_push_entry,
  input  logic                  q_full
);
  import dbt_pkg::*;

  logic                 s1_valid_r, s1_valid_nxt;
  queue_entry_t         s1_entry_r, s1_entry_nxt;
  logic                 accept;
  logic                 too_far;
  logic                 off_screen;
  logic                 idx_big;
  logic [IDX_SUM_W-1:0] idx_sum;

  always_comb begin
    busy   = bk_status.init_busy | (s1_valid_r & q_full);
    accept = start & ~busy;
    q_push = s1_valid_r & ~q_full;
    q_push_entry = s1_entry_r;

    too_far = $signed(in_req.depth) > $signed({1'b0, cfg.max_depth});
    off_screen = in_req.pixel_x[COORD_W-1] | in_req.pixel_y[COORD_W-1] |
                 ($unsigned(in_req.pixel_x) >= COORD_W'(cfg.screen_width)) |
                 ($unsigned(in_req.pixel_y) >= COORD_W'(cfg.screen_height));
    // Only meaningful when the pixel is on screen, where x and y fit these slices.
    idx_sum = IDX_SUM_W'(in_req.pixel_y[HEIGHT_W-1:0]) * IDX_SUM_W'(cfg.screen_width) +
              IDX_SUM_W'(in_req.pixel_x[WIDTH_W-1:0]);
    idx_big = 32'(idx_sum) >= STORE_ENTRIES;

    s1_entry_nxt.idx   = STORE_AW'(idx_sum);
    s1_entry_nxt.depth = in_req.depth;
    priority if (in_req.mode) begin
      s1_entry_nxt.kind = KIND_CLEAR;
    end else if (!cfg.test_enable) begin
      s1_entry_nxt.kind = KIND_PASS;
    end else if (too_far || off_screen || idx_big) begin
      s1_entry_nxt.kind = KIND_FAIL;
    end else begin
      s1_entry_nxt.kind = KIND_TEST;
    end

    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_entry_r <= s1_entry_nxt;
    end
  end

endmodule

@@ rtl/core/dbt_back.sv @@
// Back part: depth store read-modify-write, clear sweeps and result output.
module dbt_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dbt_pkg::cfg_t         cfg,
  input  logic                  q_empty,
  input  dbt_pkg::queue_entry_t q_entry,
  output logic                  q_pop,
  output dbt_pkg::back_status_t status,
  output logic                  out_valid,
  output dbt_pkg::out_rsp_t     out_rsp
);
  import dbt_pkg::*;

  back_state_t               state_r, state_nxt;
  logic [STORE_AW-1:0]       sweep_cnt_r, sweep_cnt_nxt;
  logic [DEPTH_W-1:0]        clr_val_r, clr_val_nxt;
  logic [STORE_AW-1:0]       op_idx_r, op_idx_nxt;
  logic signed [DEPTH_W-1:0] op_depth_r, op_depth_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_rsp_t                  out_rsp_r, out_rsp_nxt;
  logic                      sweep_last;
  logic signed [DEPTH_W-1:0] held;

  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [DEPTH_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [STORE_AW-1:0] ram_raddr;
  logic [DEPTH_W-1:0]  ram_rdata;

  dbt_ram #(
    .WIDTH(DEPTH_W),
    .DEPTH(STORE_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sweep_last = (sweep_cnt_r == STORE_AW'(STORE_ENTRIES - 1));
    held = $signed(ram_rdata);

    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    clr_val_nxt   = clr_val_r;
    op_idx_nxt    = op_idx_r;
    op_depth_nxt  = op_depth_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = '0;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = sweep_cnt_r;
    ram_wdata     = clr_val_r;
    ram_re        = 1'b0;
    ram_raddr     = q_entry.idx;

    unique case (state_r)
      BK_INIT: begin
        ram_we = 1'b1;
        if (sweep_last) begin
          sweep_cnt_nxt = '0;
          state_nxt     = BK_IDLE;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_entry.kind)
            KIND_PASS: begin
              out_valid_nxt      = 1'b1;
              out_rsp_nxt.passed = 1'b1;
            end
            KIND_FAIL: begin
              out_valid_nxt = 1'b1;
            end
            KIND_TEST: begin
              ram_re       = 1'b1;
              op_idx_nxt   = q_entry.idx;
              op_depth_nxt = q_entry.depth;
              state_nxt    = BK_READ;
            end
            KIND_CLEAR: begin
              clr_val_nxt   = {1'b0, cfg.max_depth};
              sweep_cnt_nxt = '0;
              state_nxt     = BK_SWEEP;
            end
            default: begin
              state_nxt = BK_IDLE;
            end
          endcase
        end
      end
      BK_READ: begin
        // Keep the nearer depth and pass when the fragment is not behind.
        if (op_depth_r < held) begin
          ram_we    = 1'b1;
          ram_waddr = op_idx_r;
          ram_wdata = op_depth_r;
        end
        out_valid_nxt      = 1'b1;
        out_rsp_nxt.passed = (op_depth_r <= held);
        state_nxt          = BK_IDLE;
      end
      BK_SWEEP: begin
        ram_we = 1'b1;
        if (sweep_last) begin
          sweep_cnt_nxt       = '0;
          out_valid_nxt       = 1'b1;
          out_rsp_nxt.cleared = 1'b1;
          state_nxt           = BK_IDLE;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    status.init_busy = (state_r == BK_INIT);
    out_valid = out_valid_r;
    out_rsp   = out_rsp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      sweep_cnt_r <= '0;
      clr_val_r   <= {1'b0, MAX_DEPTH_RST};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      clr_val_r   <= clr_val_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_idx_r   <= op_idx_nxt;
    op_depth_r <= op_depth_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

endmodule

@@ rtl/core/depth_buffer_test_unit.sv @@
// Top level of the depth buffer test unit: configuration registers and block wiring.
//
// The unit keeps one signed 24-bit depth word (8 fraction bits) for each of
// 32768 pixels and answers one request at a time with exactly one result.
// A request is taken at a clock edge where start is high and busy is low; the
// result appears for a single cycle with out_valid high, and there is no way
// to hold it off, so the receiver must take it in that cycle. Results come
// back in request order. The front part registers each classified request
// and can take a new one every cycle while busy is low, so while the back
// part is stalled it takes five requests back to back: four fill the queue
// in front of the back part and one waits in the front register. The back
// part works on one queued request at a time: a request that passes or
// fails without touching the store is answered straight from the idle
// state, a request that needs the store has its entry read from the store's
// single read port in the idle state and then compared and written back in
// the read state, and a clear request walks every entry through the single
// write port before its result. After reset the unit runs the same walk to
// load the reset maximum depth (7680) into every entry; busy stays high
// during that walk, while configuration writes are taken as usual.
// Configuration is meant to be written only when no request is outstanding.
module depth_buffer_test_unit (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        start,
  output logic                        busy,
  input  dbt_pkg::in_req_t            in_req,

  output logic                        out_valid,
  output dbt_pkg::out_rsp_t           out_rsp,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbt_pkg::CFG_AW-1:0]  paddr,
  input  logic [dbt_pkg::CFG_DW-1:0]  pwdata,
  output logic [dbt_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import dbt_pkg::*;

  // Configuration registers; the register index is the word address.
  logic                test_enable_r, test_enable_nxt;
  logic [MAXD_W-1:0]   max_depth_r, max_depth_nxt;
  logic [WIDTH_W-1:0]  screen_width_r, screen_width_nxt;
  logic [HEIGHT_W-1:0] screen_height_r, screen_height_nxt;
  logic                cfg_write;
  reg_index_t          reg_sel;
  cfg_t                cfg;

  queue_entry_t q_push_entry;
  queue_entry_t q_pop_entry;
  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  back_status_t bk_status;

  always_comb begin
    pready    = 1'b1;
    cfg_write = psel & penable & pwrite;
    reg_sel   = reg_index_t'(paddr[3:2]);

    test_enable_nxt   = test_enable_r;
    max_depth_nxt     = max_depth_r;
    screen_width_nxt  = screen_width_r;
    screen_height_nxt = screen_height_r;
    if (cfg_write) begin
      unique case (reg_sel)
        REG_TEST_ENABLE:   test_enable_nxt   = pwdata[0];
        REG_MAX_DEPTH:     max_depth_nxt     = pwdata[MAXD_W-1:0];
        REG_SCREEN_WIDTH:  screen_width_nxt  = pwdata[WIDTH_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_nxt = pwdata[HEIGHT_W-1:0];
        default:           test_enable_nxt   = test_enable_r;
      endcase
    end

    unique case (reg_sel)
      REG_TEST_ENABLE:   prdata = CFG_DW'(test_enable_r);
      REG_MAX_DEPTH:     prdata = CFG_DW'(max_depth_r);
      REG_SCREEN_WIDTH:  prdata = CFG_DW'(screen_width_r);
      REG_SCREEN_HEIGHT: prdata = CFG_DW'(screen_height_r);
      default:           prdata = '0;
    endcase

    cfg.test_enable   = test_enable_r;
    cfg.max_depth     = max_depth_r;
    cfg.screen_width  = screen_width_r;
    cfg.screen_height = screen_height_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_enable_r   <= TEST_ENABLE_RST;
      max_depth_r     <= MAX_DEPTH_RST;
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else begin
      test_enable_r   <= test_enable_nxt;
      max_depth_r     <= max_depth_nxt;
      screen_width_r  <= screen_width_nxt;
      screen_height_r <= screen_height_nxt;
    end
  end

  // The front part decides pass, fail, store test or clear for each request
  // and computes the store index, so the back part does no classification.
  dbt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req       (in_req),
    .cfg          (cfg),
    .bk_status    (bk_status),
    .q_push       (q_push),
    .q_push_entry (q_push_entry),
    .q_full       (q_full)
  );

  dbt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_pop_entry),
    .empty      (q_empty)
  );

  // The back part owns the depth store and produces every result in order.
  dbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_entry   (q_pop_entry),
    .q_pop     (q_pop),
    .status    (bk_status),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
